// ===== rtl/core/lrb_pkg.sv =====
// ----------------------------------------------------------------------------
// lrb_pkg: shared types and constants of the load replay buffer
// Operation codes, the command broadcast to the cell row and the priority
// chain record passed from cell to cell.
// ----------------------------------------------------------------------------
package lrb_pkg;

  localparam int unsigned AddrW       = 64;
  localparam int unsigned WaitW       = 4;
  localparam int unsigned MaskW       = 16;
  localparam int unsigned OccW        = 5;
  localparam int unsigned MissEntries = 16;

  localparam int unsigned InDataW  = 104;  // 64 + 4 + 16 + 16, padded to bytes
  localparam int unsigned OutDataW = 72;   // 64 + 5, padded to bytes
  localparam int unsigned OutUserW = 2;

  typedef enum logic [1:0] {
    KindPush = 2'd0,
    KindPick = 2'd1,
    KindPop  = 2'd2,
    KindNop  = 2'd3
  } kind_e;

  // Command broadcast to every cell for the accepted item
  typedef struct packed {
    logic             push;
    logic             pick;
    logic             pop;
    logic [AddrW-1:0] address;
    logic [WaitW-1:0] wait_id;
    logic [MaskW-1:0] miss_valid;
    logic [MaskW-1:0] miss_ready;
  } lrb_cmd_t;

  // Priority chain from lower-indexed cells to higher ones
  typedef struct packed {
    logic             free_found;
    logic             hit_found;
    logic [AddrW-1:0] hit_addr;
  } lrb_chain_t;

endpackage

// ===== rtl/core/load_replay_buffer_core.sv =====
// Output: a result appears in the output register in the cycle after its item
//   is accepted.
// Throughput: one item per cycle while no stalled result holds the output; the
//   push and pick searches ripple through the row of slot cells within that cycle.
// Reset: clears all slot valid bits, the fill count, the remembered pick and
//   the output valid flag; no clearing pass, the block takes items at once.
// ----------------------------------------------------------------------------
// load_replay_buffer_core: table of parked loads waiting on miss entries
// Push parks a load in the lowest free slot, pick returns the lowest slot
// whose miss entry is gone or ready, pop frees the picked slot.
// ----------------------------------------------------------------------------
module load_replay_buffer_core #(
  parameter int unsigned Depth = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [63:0] load_address, [67:64] wait_id, [83:68] miss_valid_mask,
  // [99:84] miss_ready_mask, [103:100] zero
  input  logic [lrb_pkg::InDataW-1:0]   s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [63:0] ready_address, [68:64] occupancy, [71:69] zero
  output logic [lrb_pkg::OutDataW-1:0]  m_axis_tdata,
  // [0] ok, [1] error
  output logic [lrb_pkg::OutUserW-1:0]  m_axis_tuser
);

  localparam int unsigned SlotW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic                       accept;
  lrb_pkg::kind_e             kind;
  lrb_pkg::lrb_cmd_t          cmd;
  lrb_pkg::lrb_chain_t        chain [Depth+1];
  logic [SlotW-1:0]           slot_chain [Depth+1];
  logic [Depth-1:0]           cell_valid;
  logic                       pop_ok;

  logic                       picked_valid_q, picked_valid_d;
  logic [SlotW-1:0]           picked_slot_q, picked_slot_d;
  logic [CntW-1:0]            fill_q, fill_d;

  logic                       out_valid_q, out_valid_d;
  logic                       ok_q, ok_d;
  logic                       err_q, err_d;
  logic [lrb_pkg::AddrW-1:0]  raddr_q, raddr_d;
  logic [lrb_pkg::OccW-1:0]   occ_q;

  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign kind          = lrb_pkg::kind_e'(s_axis_tuser);

  always_comb begin
    cmd.push       = accept & (kind == lrb_pkg::KindPush);
    cmd.pick       = accept & (kind == lrb_pkg::KindPick);
    cmd.pop        = pop_ok;
    cmd.address    = s_axis_tdata[63:0];
    cmd.wait_id    = s_axis_tdata[67:64];
    cmd.miss_valid = s_axis_tdata[83:68];
    cmd.miss_ready = s_axis_tdata[99:84];
  end

  // Pop only frees a slot that a pick remembered and that is still parked
  assign pop_ok = accept & (kind == lrb_pkg::KindPop) & picked_valid_q
                & cell_valid[picked_slot_q];

  assign chain[0]      = '0;
  assign slot_chain[0] = '0;

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    lrb_cell #(
      .SlotW   (SlotW),
      .CellIdx (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .pop_slot_i (picked_slot_q),
      .chain_i    (chain[g]),
      .slot_i     (slot_chain[g]),
      .chain_o    (chain[g+1]),
      .slot_o     (slot_chain[g+1]),
      .valid_o    (cell_valid[g])
    );
  end

  always_comb begin
    fill_d         = fill_q;
    picked_valid_d = picked_valid_q;
    picked_slot_d  = picked_slot_q;
    if (cmd.push && chain[Depth].free_found) begin
      fill_d = fill_q + CntW'(1);
    end
    if (cmd.pick) begin
      picked_valid_d = chain[Depth].hit_found;
      if (chain[Depth].hit_found) begin
        picked_slot_d = slot_chain[Depth];
      end
    end
    if (pop_ok) begin
      fill_d         = fill_q - CntW'(1);
      picked_valid_d = 1'b0;
    end
  end

  always_comb begin
    ok_d    = 1'b0;
    err_d   = 1'b0;
    raddr_d = '0;
    case (kind)
      lrb_pkg::KindPush: begin
        ok_d = chain[Depth].free_found;
      end
      lrb_pkg::KindPick: begin
        ok_d    = chain[Depth].hit_found;
        raddr_d = chain[Depth].hit_addr;
      end
      lrb_pkg::KindPop: begin
        ok_d  = pop_ok;
        err_d = ~pop_ok;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q    <= 1'b0;
      fill_q         <= '0;
      picked_valid_q <= 1'b0;
      picked_slot_q  <= '0;
    end else begin
      out_valid_q    <= out_valid_d;
      fill_q         <= fill_d;
      picked_valid_q <= picked_valid_d;
      picked_slot_q  <= picked_slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q    <= ok_d;
      err_q   <= err_d;
      raddr_q <= raddr_d;
      occ_q   <= lrb_pkg::OccW'(fill_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, occ_q, raddr_q};
  assign m_axis_tuser  = {err_q, ok_q};

endmodule

// ===== rtl/core/lrb_cell.sv =====
// ----------------------------------------------------------------------------
// lrb_cell: one slot of the load replay buffer
// Holds a parked load and takes part in the lowest-free and lowest-ready
// priority chains that run along the row of cells.
// ----------------------------------------------------------------------------
module lrb_cell #(
  parameter int unsigned SlotW   = 4,
  parameter int unsigned CellIdx = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lrb_pkg::lrb_cmd_t    cmd_i,
  input  logic [SlotW-1:0]     pop_slot_i,
  input  lrb_pkg::lrb_chain_t  chain_i,
  input  logic [SlotW-1:0]     slot_i,
  output lrb_pkg::lrb_chain_t  chain_o,
  output logic [SlotW-1:0]     slot_o,
  output logic                 valid_o
);

  logic                        valid_q, valid_d;
  logic [lrb_pkg::AddrW-1:0]   addr_q;
  logic [lrb_pkg::WaitW-1:0]   wait_q;
  logic                        in_range;
  logic                        miss_v;
  logic                        miss_r;
  logic                        ready;
  logic                        take;
  logic                        hit;
  logic                        clear;

  // Waited-on entries beyond the tracked miss entries count as gone
  assign in_range = (int'(wait_q) < lrb_pkg::MissEntries);
  assign miss_v   = in_range & cmd_i.miss_valid[wait_q];
  assign miss_r   = in_range & cmd_i.miss_ready[wait_q];
  assign ready    = valid_q & (~miss_v | miss_r);

  assign take  = cmd_i.push & ~valid_q & ~chain_i.free_found;
  assign hit   = cmd_i.pick & ready & ~chain_i.hit_found;
  assign clear = cmd_i.pop & (pop_slot_i == SlotW'(CellIdx));

  always_comb begin
    chain_o.free_found = chain_i.free_found | ~valid_q;
    chain_o.hit_found  = chain_i.hit_found | ready;
    chain_o.hit_addr   = hit ? addr_q : chain_i.hit_addr;
    slot_o             = hit ? SlotW'(CellIdx) : slot_i;
  end

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (clear) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      addr_q <= cmd_i.address;
      wait_q <= cmd_i.wait_id;
    end
  end

  assign valid_o = valid_q;

endmodule

// ===== rtl/core/lrb_checker.sv =====
// ----------------------------------------------------------------------------
// lrb_checker: port-level checks of the load replay buffer
// Watches both stream ports and flags results that break the block's rules.
// ----------------------------------------------------------------------------
module lrb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [lrb_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic [lrb_pkg::OutUserW-1:0]  m_axis_tuser
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // An empty output register never blocks the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("ok and error both set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[1] || !m_axis_tuser[0]) |-> m_axis_tdata[63:0] == 64'd0)
    else $error("address reported without a successful pick");

endmodule

bind load_replay_buffer_core lrb_checker u_lrb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
